### hw/rtl/zone_write_admission_defines.svh
// Assertion macros used by the zone write admission checker.
`ifndef ZONE_WRITE_ADMISSION_DEFINES_SVH
`define ZONE_WRITE_ADMISSION_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define ZWA_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zone write admission: implication violated");

// Checks that the consequent follows the antecedent.
`define ZWA_ASSERT_AFTER2(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("zone write admission: latency violated");

`endif

### hw/rtl/zwa_pkg.sv
// Package with the types, codes and defaults of the zone write admission block.
package zwa_pkg;

    localparam int DEF_NUM_ZONES = 64;
    localparam int DEF_LBA_BITS  = 32;

    localparam int WP_W  = 27;
    localparam int CNT_W = 7;
    localparam int NR_W  = 17;

    localparam logic [2:0] COND_EMPTY   = 3'd0;
    localparam logic [2:0] COND_IOPEN   = 3'd1;
    localparam logic [2:0] COND_EOPEN   = 3'd2;
    localparam logic [2:0] COND_CLOSED  = 3'd3;
    localparam logic [2:0] COND_FULL    = 3'd4;
    localparam logic [2:0] COND_RONLY   = 3'd5;
    localparam logic [2:0] COND_OFFLINE = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_BOUNDARY  = 3'd2;
    localparam logic [2:0] ST_NO_ACTIVE = 3'd3;
    localparam logic [2:0] ST_NO_OPEN   = 3'd4;
    localparam logic [2:0] ST_RONLY     = 3'd5;
    localparam logic [2:0] ST_OFFLINE   = 3'd6;
    localparam logic [2:0] ST_RANGE     = 3'd7;

    localparam logic [2:0] REG_ZONE_SIZE_LOG2   = 3'd0;
    localparam logic [2:0] REG_ZONE_CAP         = 3'd1;
    localparam logic [2:0] REG_WRITE_UNIT_LOG2  = 3'd2;
    localparam logic [2:0] REG_MAX_OPEN_ZONES   = 3'd3;
    localparam logic [2:0] REG_MAX_ACTIVE_ZONES = 3'd4;

    typedef struct packed {
        logic [2:0]      cond;
        logic [WP_W-1:0] wp;
    } zwa_entry_t;

    typedef struct packed {
        logic            op;
        logic            in_range;
        logic            spans;
        logic [31:0]     off;
        logic [NR_W-1:0] nr;
    } zwa_cmd_t;

    typedef struct packed {
        logic [4:0]       zone_size_log2;
        logic [WP_W-1:0]  zone_cap;
        logic [3:0]       write_unit_log2;
        logic [CNT_W-1:0] max_open_zones;
        logic [CNT_W-1:0] max_active_zones;
    } zwa_cfg_t;

    typedef struct packed {
        logic [2:0]       status;
        zwa_entry_t       entry;
        logic [CNT_W-1:0] open_cnt;
        logic [CNT_W-1:0] active_cnt;
        logic             full;
        logic             over;
        logic             wr_en;
    } zwa_decision_t;

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - CNT_W'(1) : '0;
    endfunction

endpackage

### hw/rtl/zwa_decide.sv
// Decision logic for one command against the state of its zone and the slot counts.
module zwa_decide
    import zwa_pkg::*;
(
    input  zwa_cmd_t         cmd,
    input  zwa_entry_t       entry,
    input  zwa_cfg_t         cfg,
    input  logic [CNT_W-1:0] open_cnt,
    input  logic [CNT_W-1:0] active_cnt,
    output zwa_decision_t    dec
);

    always_comb
    begin
        logic [NR_W-1:0]  unit_mask;
        logic             unit_bad;
        logic             at_ptr;
        logic [WP_W-1:0]  wp_base;
        logic             need_active;
        logic             need_open;
        logic [2:0]       st;
        logic [CNT_W-1:0] open_mid;
        logic [CNT_W-1:0] act_mid;
        logic [WP_W-1:0]  nwp;
        logic [2:0]       cond_new;

        unit_mask   = (NR_W'(1) << cfg.write_unit_log2) - NR_W'(1);
        unit_bad    = |(cmd.nr & unit_mask);
        at_ptr      = (cmd.off == {{(32 - WP_W){1'b0}}, entry.wp});
        wp_base     = entry.wp;
        need_active = 1'b0;
        need_open   = 1'b0;
        st          = ST_OK;
        open_mid    = open_cnt;
        act_mid     = active_cnt;
        nwp         = entry.wp;
        cond_new    = entry.cond;

        dec.full       = 1'b0;
        dec.over       = 1'b0;
        dec.wr_en      = 1'b0;

        if (!cmd.in_range)
        begin
            st  = ST_RANGE;
            nwp = '0;
        end
        else if (!cmd.op)
        begin
            if (entry.cond == COND_OFFLINE)
            begin
                st = ST_OFFLINE;
            end
            else if (cmd.spans)
            begin
                st = ST_BOUNDARY;
            end
        end
        else
        begin
            dec.wr_en = 1'b1;
            if (unit_bad)
            begin
                st = ST_INVALID;
            end
            else if (cmd.spans)
            begin
                st = ST_BOUNDARY;
            end
            else if (entry.cond != COND_FULL && !at_ptr)
            begin
                st = ST_INVALID;
            end
            else
            begin
                // A full zone is implicitly reset before the write is checked further.
                if (entry.cond == COND_FULL)
                begin
                    wp_base = '0;
                end
                case (entry.cond) inside
                    COND_EMPTY, COND_FULL:
                    begin
                        if (cmd.off != '0)
                        begin
                            st = ST_INVALID;
                        end
                        else if (active_cnt >= cfg.max_active_zones)
                        begin
                            st = ST_NO_ACTIVE;
                        end
                        else if (open_cnt >= cfg.max_open_zones)
                        begin
                            st = ST_NO_OPEN;
                        end
                        else
                        begin
                            need_active = 1'b1;
                            need_open   = 1'b1;
                        end
                    end
                    COND_CLOSED:
                    begin
                        if (open_cnt >= cfg.max_open_zones)
                        begin
                            st = ST_NO_OPEN;
                        end
                        else
                        begin
                            need_open = 1'b1;
                        end
                    end
                    COND_RONLY:
                    begin
                        st = ST_RONLY;
                    end
                    COND_OFFLINE:
                    begin
                        st = ST_OFFLINE;
                    end
                    default:
                    begin
                    end
                endcase
            end

            nwp = wp_base;
            if (st == ST_OK)
            begin
                act_mid  = active_cnt + CNT_W'(need_active);
                open_mid = open_cnt + CNT_W'(need_open);
                if (need_open)
                begin
                    cond_new = COND_IOPEN;
                end
                nwp = wp_base + WP_W'(cmd.nr);
                if (nwp == cfg.zone_cap)
                begin
                    open_mid = count_down(open_mid);
                    act_mid  = count_down(act_mid);
                    cond_new = COND_FULL;
                    dec.full = 1'b1;
                end
                else if (nwp > cfg.zone_cap)
                begin
                    dec.over = 1'b1;
                end
            end
        end

        dec.status     = st;
        dec.entry.cond = cond_new;
        dec.entry.wp   = nwp;
        dec.open_cnt   = open_mid;
        dec.active_cnt = act_mid;
    end

endmodule

### hw/rtl/zone_write_admission.sv
// Top level of the zone write admission block: registers, zone store and pipeline.
//
// A command is accepted at a rising clock edge with start high and busy low. It carries
// op (read check or write), cmd_lba and lba_count_minus_one. Its one result appears
// on status, zone_index, write_ptr_offset, zone_became_full and overrun, marked by done
// for exactly one cycle; it passes through the command register and the result registers.
// While busy is low the block takes one command in every cycle: the command is
// registered while the zone store is read, and the decision, the store write-back and
// the slot counts are settled in the next cycle. A write-back to the zone that the
// following command reads is forwarded, so back-to-back commands to one zone see
// each other's updates. After reset busy stays high while every zone is cleared to
// empty with a zero write pointer, one zone in each cycle; the slot counts start at
// zero and the configuration registers take their default values. Configuration is
// written over the APB port and must only change while no transaction is in flight.
// The receiver cannot stall: each result is taken in the cycle in which done is high.
module zone_write_admission
    import zwa_pkg::*;
#(
    parameter int NUM_ZONES = DEF_NUM_ZONES,
    parameter int LBA_BITS  = DEF_LBA_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [31:0] cmd_lba,
    input  logic [15:0] lba_count_minus_one,

    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  zone_index,
    output logic [26:0] write_ptr_offset,
    output logic        zone_became_full,
    output logic        overrun
);

    localparam int ZONE_BITS = $clog2(NUM_ZONES);
    localparam logic [31:0] LBA_MASK = (LBA_BITS >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << LBA_BITS) - 64'd1);

    logic [4:0]       zone_size_log2_reg;
    logic [WP_W-1:0]  zone_cap_reg;
    logic [3:0]       write_unit_log2_reg;
    logic [CNT_W-1:0] max_open_zones_reg;
    logic [CNT_W-1:0] max_active_zones_reg;

    logic                 clr_active_reg;
    logic [ZONE_BITS-1:0] clr_addr_reg;

    logic                 s1_valid_reg;
    zwa_cmd_t             s1_cmd_reg;
    logic [ZONE_BITS-1:0] s1_zone_reg;
    logic [5:0]           s1_zidx_reg;
    zwa_entry_t           rd_entry_reg;

    logic                 fwd_valid_reg;
    logic [ZONE_BITS-1:0] fwd_zone_reg;
    zwa_entry_t           fwd_entry_reg;

    logic [CNT_W-1:0] open_cnt_reg;
    logic [CNT_W-1:0] active_cnt_reg;

    logic             done_reg;
    logic [2:0]       status_reg;
    logic [5:0]       zone_index_reg;
    logic [WP_W-1:0]  write_ptr_offset_reg;
    logic             zone_became_full_reg;
    logic             overrun_reg;

    zwa_entry_t zone_mem [NUM_ZONES];

    logic                 cfg_write;
    logic                 accept;
    logic [31:0]          slba;
    logic [31:0]          zid;
    logic [32:0]          zend;
    zwa_cmd_t             cmd_next;
    zwa_entry_t           entry_cur;
    zwa_cfg_t             cfg;
    zwa_decision_t        dec;
    logic                 mem_we;
    logic [ZONE_BITS-1:0] mem_waddr;
    zwa_entry_t           mem_wdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_size_log2_reg   <= 5'd16;
            zone_cap_reg         <= WP_W'(65536);
            write_unit_log2_reg  <= 4'd0;
            max_open_zones_reg   <= CNT_W'(14);
            max_active_zones_reg <= CNT_W'(14);
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_ZONE_SIZE_LOG2:   zone_size_log2_reg   <= pwdata[4:0];
                REG_ZONE_CAP:         zone_cap_reg         <= pwdata[WP_W-1:0];
                REG_WRITE_UNIT_LOG2:  write_unit_log2_reg  <= pwdata[3:0];
                REG_MAX_OPEN_ZONES:   max_open_zones_reg   <= pwdata[CNT_W-1:0];
                REG_MAX_ACTIVE_ZONES: max_active_zones_reg <= pwdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ZONE_SIZE_LOG2:   prdata = 32'(zone_size_log2_reg);
            REG_ZONE_CAP:         prdata = 32'(zone_cap_reg);
            REG_WRITE_UNIT_LOG2:  prdata = 32'(write_unit_log2_reg);
            REG_MAX_OPEN_ZONES:   prdata = 32'(max_open_zones_reg);
            REG_MAX_ACTIVE_ZONES: prdata = 32'(max_active_zones_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.zone_size_log2   = zone_size_log2_reg;
    assign cfg.zone_cap         = zone_cap_reg;
    assign cfg.write_unit_log2  = write_unit_log2_reg;
    assign cfg.max_open_zones   = max_open_zones_reg;
    assign cfg.max_active_zones = max_active_zones_reg;

    assign busy   = clr_active_reg;
    assign accept = start && !busy;

    // Zone clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ZONE_BITS'(1);
            if (clr_addr_reg == ZONE_BITS'(NUM_ZONES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign slba = cmd_lba & LBA_MASK;
    assign zid  = slba >> zone_size_log2_reg;
    assign zend = ({1'b0, slba} + 33'(lba_count_minus_one)) >> zone_size_log2_reg;

    assign cmd_next.op       = op;
    assign cmd_next.in_range = (zid < 32'(NUM_ZONES));
    assign cmd_next.spans    = (zend != {1'b0, zid});
    assign cmd_next.off      = slba & ~(32'hFFFF_FFFF << zone_size_log2_reg);
    assign cmd_next.nr       = NR_W'(lba_count_minus_one) + NR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_next;
            s1_zone_reg <= zid[ZONE_BITS-1:0];
            s1_zidx_reg <= zid[5:0];
        end
    end

    assign mem_we    = clr_active_reg || (s1_valid_reg && dec.wr_en);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : s1_zone_reg;
    assign mem_wdata = clr_active_reg ? zwa_entry_t'{cond: COND_EMPTY, wp: '0} : dec.entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            zone_mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= zone_mem[zid[ZONE_BITS-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= s1_valid_reg && dec.wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_zone_reg  <= s1_zone_reg;
        fwd_entry_reg <= dec.entry;
    end

    assign entry_cur = (fwd_valid_reg && fwd_zone_reg == s1_zone_reg) ? fwd_entry_reg
                                                                      : rd_entry_reg;

    zwa_decide u_decide
    (
        .cmd        (s1_cmd_reg),
        .entry      (entry_cur),
        .cfg        (cfg),
        .open_cnt   (open_cnt_reg),
        .active_cnt (active_cnt_reg),
        .dec        (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_cnt_reg   <= '0;
            active_cnt_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                open_cnt_reg   <= dec.open_cnt;
                active_cnt_reg <= dec.active_cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            status_reg           <= dec.status;
            zone_index_reg       <= s1_zidx_reg;
            write_ptr_offset_reg <= dec.entry.wp;
            zone_became_full_reg <= dec.full;
            overrun_reg          <= dec.over;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign zone_index       = zone_index_reg;
    assign write_ptr_offset = write_ptr_offset_reg;
    assign zone_became_full = zone_became_full_reg;
    assign overrun          = overrun_reg;

endmodule

### hw/rtl/zwa_checker.sv
// Port-level checker for the zone write admission block and its bind.
`include "zone_write_admission_defines.svh"

module zwa_checker
    import zwa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [26:0] write_ptr_offset,
    input logic        zone_became_full,
    input logic        overrun
);

    logic no_flags;

    assign no_flags = !zone_became_full && !overrun;

    `ZWA_ASSERT_AFTER2(a_result_follows, start && !busy, done)
    `ZWA_ASSERT_IMPLY(a_result_has_cause, done, $past(start && !busy, 2))
    `ZWA_ASSERT_IMPLY(a_range_clean, done && status == ST_RANGE, write_ptr_offset == '0 && no_flags)
    `ZWA_ASSERT_IMPLY(a_error_no_flags, done && status != ST_OK, no_flags)

endmodule

bind zone_write_admission zwa_checker u_zwa_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .write_ptr_offset (write_ptr_offset),
    .zone_became_full (zone_became_full),
    .overrun          (overrun)
);
